/* hdl/bpu_pkg.sv */
// Shared types, codes and helper functions of the palette pixel unpacker.
package bpu_pkg;

  // Command codes carried on the input tuser bit.
  localparam logic CMD_PAL_WRITE  = 1'b0;
  localparam logic CMD_PIXEL_BYTE = 1'b1;

  // Configuration register indexes.
  localparam logic [1:0] REG_BPP        = 2'd0;
  localparam logic [1:0] REG_WIDTH      = 2'd1;
  localparam logic [1:0] REG_HEIGHT     = 2'd2;
  localparam logic [1:0] REG_THREE_BYTE = 2'd3;

  // Reset values of the configuration registers.
  localparam logic [3:0]  BPP_RESET    = 4'd8;
  localparam logic [12:0] WIDTH_RESET  = 13'd1;
  localparam logic [12:0] HEIGHT_RESET = 13'd1;

  typedef enum logic {
    KIND_PAL_WRITE,
    KIND_PIXEL_BYTE
  } kind_e;

  // One classified beat held in the queue between front and back.
  typedef struct packed {
    kind_e       kind;
    logic [7:0]  pal_index;
    logic [31:0] pal_color;
    logic [7:0]  data_byte;
  } item_t;

  typedef struct packed {
    logic [3:0]  bpp;
    logic [12:0] width;
    logic [12:0] height;
    logic        three_byte;
  } cfg_t;

  typedef struct packed {
    logic image_end;
    logic row_end;
    logic last_of_byte;
  } pix_flags_t;

  typedef struct packed {
    logic [31:0] color;
    pix_flags_t  flags;
  } pixel_t;

  // True for the index widths the block handles.
  function automatic logic bpp_valid(input logic [3:0] bpp);
    bpp_valid = (bpp == 4'd1) || (bpp == 4'd2) || (bpp == 4'd4) || (bpp == 4'd8);
  endfunction

  // Base-two logarithm of a valid index width.
  function automatic logic [1:0] bpp_log2(input logic [3:0] bpp);
    logic [1:0] lg;
    case (bpp)
      4'd2:    lg = 2'd1;
      4'd4:    lg = 2'd2;
      4'd8:    lg = 2'd3;
      default: lg = 2'd0;
    endcase
    bpp_log2 = lg;
  endfunction

endpackage

/* hdl/bpu_fifo.sv */
// Two-entry register queue with valid/ready on both sides.
module bpu_fifo
  import bpu_pkg::*;
#(
  parameter int WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [WIDTH-1:0] in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [WIDTH-1:0] out_data_o,
  output logic [1:0]       count_o
);

  localparam logic [1:0] Full = 2'd2;

  logic [WIDTH-1:0] data_q [2];
  logic [1:0]       count_q, count_d;
  logic             wr_q, rd_q;
  logic             push, pop;

  assign in_ready_o  = (count_q != Full);
  assign out_valid_o = (count_q != 2'd0);
  assign out_data_o  = data_q[rd_q];
  assign count_o     = count_q;
  assign push        = in_valid_i && in_ready_o;
  assign pop         = out_valid_o && out_ready_i;

  always_comb begin
    count_d = count_q;
    if (push && !pop) begin
      count_d = 2'(count_q + 2'd1);
    end else if (pop && !push) begin
      count_d = 2'(count_q - 2'd1);
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 2'd0;
      wr_q    <= 1'b0;
      rd_q    <= 1'b0;
    end else begin
      count_q <= count_d;
      if (push) wr_q <= ~wr_q;
      if (pop) rd_q <= ~rd_q;
    end
  end

  // Storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (push) data_q[wr_q] <= in_data_i;
  end

endmodule

/* hdl/bpu_front.sv */
// Input side: classifies each beat and queues it for the expansion engine.
module bpu_front
  import bpu_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_t        cfg_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        in_cmd_i,
  input  logic [7:0]  in_pal_index_i,
  input  logic [31:0] in_pal_color_i,
  input  logic [7:0]  in_data_byte_i,
  output logic        item_valid_o,
  input  logic        item_ready_i,
  output item_t       item_o
);

  item_t item;
  logic  keep;
  logic  q_ready;

  // A pixel byte under an unsupported index width is taken and dropped here.
  always_comb begin
    item.kind      = (in_cmd_i == CMD_PAL_WRITE) ? KIND_PAL_WRITE : KIND_PIXEL_BYTE;
    item.pal_index = in_pal_index_i;
    item.pal_color = in_pal_color_i;
    item.data_byte = in_data_byte_i;
    keep           = (in_cmd_i == CMD_PAL_WRITE) || bpp_valid(cfg_i.bpp);
  end

  assign in_ready_o = q_ready;

  bpu_fifo #(
    .WIDTH($bits(item_t))
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i && keep),
    .in_ready_o (q_ready),
    .in_data_i  (item),
    .out_valid_o(item_valid_o),
    .out_ready_i(item_ready_i),
    .out_data_o (item_o),
    .count_o    ()
  );

endmodule

/* hdl/bpu_back.sv */
// Expansion engine: palette store, per-pixel sequencer, lookup stage and
// output buffer.
module bpu_back
  import bpu_pkg::*;
#(
  parameter int PALETTE_DEPTH = 256,
  parameter int MAX_WIDTH     = 4096
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  cfg_t   cfg_i,
  input  logic   item_valid_i,
  output logic   item_ready_o,
  input  item_t  item_i,
  output logic   out_valid_o,
  input  logic   out_ready_i,
  output pixel_t out_o
);

  localparam int AW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;

  // Palette store and the per-entry written marks.
  logic [31:0]              mem_q [PALETTE_DEPTH];
  logic [PALETTE_DEPTH-1:0] valid_q;

  // Position state.
  logic [12:0] col_q, col_d;
  logic [12:0] row_q, row_d;
  logic [1:0]  pad_q, pad_d;
  logic        done_q, done_d;
  logic        started_q, started_d;
  logic [2:0]  c_q, c_d;

  // Lookup stage.
  logic        rd_valid_q;
  logic [31:0] rd_data_q;
  logic        rd_zero_q;
  pix_flags_t  rd_flags_q;

  logic [1:0]  ocount;
  logic        opop;
  logic [2:0]  occ;
  logic        credit_ok;

  logic [1:0]  lg;
  logic [2:0]  per_m1;
  logic [2:0]  cur_c;
  logic [12:0] w_eff;
  logic [12:0] h_eff;
  logic [12:0] w_nz;
  logic        row_last;
  logic        img_last;
  logic [4:0]  bits_lo;
  logic [1:0]  bytes_lo;
  logic [1:0]  pad_new;
  logic [2:0]  shamt;
  logic [7:0]  mask;
  logic [7:0]  idx;
  logic        idx_in_range;
  logic        wr_in_range;
  logic        is_pix;
  logic        palw;
  logic        drop;
  logic        issue;
  logic        byte_last;
  pixel_t      opix;

  // Geometry after the out-of-range rules.
  always_comb begin
    w_nz  = (cfg_i.width == 13'd0) ? 13'd1 : cfg_i.width;
    w_eff = ({4'd0, w_nz} > 17'(MAX_WIDTH)) ? 13'(MAX_WIDTH) : w_nz;
    h_eff = (cfg_i.height == 13'd0) ? 13'd1 : cfg_i.height;
  end

  // Padding bytes of a row: the low bits of the row's bit count decide it.
  always_comb begin
    lg       = bpp_log2(cfg_i.bpp);
    bits_lo  = 5'(5'(w_eff) << lg);
    bytes_lo = 2'(bits_lo[4:3] + {1'b0, (bits_lo[2:0] != 3'd0)});
    pad_new  = 2'(2'd0 - bytes_lo);
  end

  // Pixel selection within the current byte, most significant first.
  always_comb begin
    per_m1   = 3'((4'd8 >> lg) - 4'd1);
    cur_c    = started_q ? c_q : per_m1;
    shamt    = 3'({3'd0, cur_c} << lg);
    mask     = 8'((9'd1 << cfg_i.bpp) - 9'd1);
    idx      = (item_i.data_byte >> shamt) & mask;
    row_last = ({1'b0, col_q} + 14'd1) >= {1'b0, w_eff};
    img_last = row_last && (({1'b0, row_q} + 14'd1) >= {1'b0, h_eff});
    idx_in_range = {1'b0, idx} < 9'(PALETTE_DEPTH);
    wr_in_range  = {1'b0, item_i.pal_index} < 9'(PALETTE_DEPTH);
  end

  // A lookup is issued only when its result is sure of a place in the buffer.
  always_comb begin
    opop      = out_valid_o && out_ready_i;
    occ       = 3'({1'b0, ocount} + {2'd0, rd_valid_q} - {2'd0, opop});
    credit_ok = occ < 3'd2;
    is_pix    = item_valid_i && (item_i.kind == KIND_PIXEL_BYTE);
    palw      = item_valid_i && (item_i.kind == KIND_PAL_WRITE);
    drop      = is_pix && !started_q && (done_q || (pad_q != 2'd0));
    issue     = is_pix && !drop && credit_ok;
    byte_last = (cur_c == 3'd0) || row_last;
    item_ready_o = palw || drop || (issue && byte_last);
  end

  // Next position state.
  always_comb begin
    col_d     = col_q;
    row_d     = row_q;
    pad_d     = pad_q;
    done_d    = done_q;
    started_d = started_q;
    c_d       = c_q;
    if (drop) begin
      if (!done_q) pad_d = 2'(pad_q - 2'd1);
    end else if (issue) begin
      if (row_last) begin
        col_d = 13'd0;
        if (img_last) begin
          done_d = 1'b1;
          pad_d  = 2'd0;
        end else begin
          row_d = 13'(row_q + 13'd1);
          pad_d = pad_new;
        end
      end else begin
        col_d = 13'(col_q + 13'd1);
      end
      if (byte_last) begin
        started_d = 1'b0;
      end else begin
        started_d = 1'b1;
        c_d       = 3'(cur_c - 3'd1);
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= 13'd0;
      row_q      <= 13'd0;
      pad_q      <= 2'd0;
      done_q     <= 1'b0;
      started_q  <= 1'b0;
      c_q        <= 3'd0;
      rd_valid_q <= 1'b0;
      valid_q    <= '0;
    end else begin
      col_q      <= col_d;
      row_q      <= row_d;
      pad_q      <= pad_d;
      done_q     <= done_d;
      started_q  <= started_d;
      c_q        <= c_d;
      rd_valid_q <= issue;
      if (palw && wr_in_range) valid_q[item_i.pal_index[AW-1:0]] <= 1'b1;
    end
  end

  // Palette memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (palw && wr_in_range) mem_q[item_i.pal_index[AW-1:0]] <= item_i.pal_color;
    if (issue) begin
      rd_data_q  <= mem_q[idx[AW-1:0]];
      rd_zero_q  <= !idx_in_range || !valid_q[idx[AW-1:0]];
      rd_flags_q <= '{image_end: img_last, row_end: row_last, last_of_byte: byte_last};
    end
  end

  // Unwritten and out-of-range entries read as zero; mask for 3-byte entries.
  always_comb begin
    opix.color = rd_zero_q ? 32'd0 : rd_data_q;
    if (cfg_i.three_byte) opix.color[31:24] = 8'd0;
    opix.flags = rd_flags_q;
  end

  bpu_fifo #(
    .WIDTH($bits(pixel_t))
  ) u_obuf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (rd_valid_q),
    .in_ready_o (),
    .in_data_i  (opix),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_o),
    .count_o    (ocount)
  );

endmodule

/* hdl/bmp_palette_pixel_unpacker.sv */
// Top level of the palette pixel unpacker: configuration registers and the
// two halves of the datapath.
//
// Input beats carry either a palette write (tuser low) or one packed pixel
// data byte (tuser high). Palette writes fill a 32-bit colour store; each
// data byte is split into 1, 2, 4 or 8-bit indices, most significant first,
// and every index leaves as one output beat holding its palette colour.
// Output tlast marks the last pixel of a row; tuser flags the last pixel of
// the byte and the last pixel of the image. Row padding bytes and bytes
// after the image give no output beats.
// The first pixel of a byte passes from the input queue through the lookup
// stage register and the output buffer. The lookup sequencer produces one
// pixel per cycle while the output buffer has room, through the single read
// port of the palette memory; a palette write or a swallowed byte needs no
// lookup. A two-beat queue parts the input from the sequencer, and a two-beat
// output buffer lets the sequencer run on while a pixel waits. When the
// receiver stalls, the output buffer fills and the sequencer and then the
// input queue hold. Reset clears the position state and marks every palette
// entry unwritten, so it reads as zero; no clearing pass is needed. The user
// must write configuration only while the block is idle; nothing enforces it.
module bmp_palette_pixel_unpacker
  import bpu_pkg::*;
#(
  parameter int PALETTE_DEPTH = 256,
  parameter int MAX_WIDTH     = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_addr_i,
  input  logic [12:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // palette_index [7:0], palette_color [39:8], data_byte [47:40]
  input  logic [47:0] s_axis_tdata,
  // cmd [0]
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // pixel_color [31:0]
  output logic [31:0] m_axis_tdata,
  output logic        m_axis_tlast,
  // last_of_byte [0], image_end [1]
  output logic [1:0]  m_axis_tuser
);

  cfg_t   cfg_q;
  logic   item_valid;
  logic   item_ready;
  item_t  item;
  pixel_t pix;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.bpp        <= BPP_RESET;
      cfg_q.width      <= WIDTH_RESET;
      cfg_q.height     <= HEIGHT_RESET;
      cfg_q.three_byte <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        REG_BPP:        cfg_q.bpp        <= cfg_wdata_i[3:0];
        REG_WIDTH:      cfg_q.width      <= cfg_wdata_i;
        REG_HEIGHT:     cfg_q.height     <= cfg_wdata_i;
        REG_THREE_BYTE: cfg_q.three_byte <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  bpu_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_o    (s_axis_tready),
    .in_cmd_i      (s_axis_tuser),
    .in_pal_index_i(s_axis_tdata[7:0]),
    .in_pal_color_i(s_axis_tdata[39:8]),
    .in_data_byte_i(s_axis_tdata[47:40]),
    .item_valid_o  (item_valid),
    .item_ready_i  (item_ready),
    .item_o        (item)
  );

  bpu_back #(
    .PALETTE_DEPTH(PALETTE_DEPTH),
    .MAX_WIDTH    (MAX_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .item_valid_i(item_valid),
    .item_ready_o(item_ready),
    .item_i      (item),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_o       (pix)
  );

  assign m_axis_tdata = pix.color;
  assign m_axis_tlast = pix.flags.row_end;
  assign m_axis_tuser = {pix.flags.image_end, pix.flags.last_of_byte};

endmodule

/* verif/bmp_palette_pixel_unpacker_tb.sv */
// Self-checking testbench for the palette pixel unpacker: stream driver, monitor and predictor.
module bmp_palette_pixel_unpacker_tb;
  import bpu_pkg::*;

  localparam int MAX_ROW_PIXELS = 4096;
  localparam int RANDOM_BEATS   = 370;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_addr_i = REG_BPP;
  logic [12:0] cfg_wdata_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;  // palette_index [7:0], palette_color [39:8], data_byte [47:40]
  logic        s_axis_tuser = CMD_PAL_WRITE;  // cmd [0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;  // pixel_color [31:0]
  logic        m_axis_tlast;
  logic [1:0]  m_axis_tuser;  // last_of_byte [0], image_end [1]

  // Predictor state and its copy of the configuration registers.
  cfg_t        regs = '{bpp: BPP_RESET, width: WIDTH_RESET, height: HEIGHT_RESET,
                        three_byte: 1'b0};
  logic [31:0] pal_mem [256] = '{default: '0};
  logic [12:0] col_pos = '0;
  logic [12:0] row_pos = '0;
  logic [1:0]  pad_left = '0;
  logic        img_done = 1'b0;

  item_t  beats_to_send [$];
  pixel_t pixels_due [$];
  item_t  cur_beat;
  int     tx_idle_pct = 23;
  int     rx_idle_pct = 78;
  int     mismatches = 0;
  int     pixel_count = 0;
  int     n_random = 0;
  bit     hold_go = 1'b0;
  logic   rx_hold = 1'b0;

  bmp_palette_pixel_unpacker u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #6 clk_i = ~clk_i;

  // Number of indices in one data byte; zero marks an unsupported index width.
  function automatic int pixels_per_byte(input logic [3:0] bpp);
    case (bpp)
      4'd1:    return 8;
      4'd2:    return 4;
      4'd4:    return 2;
      4'd8:    return 1;
      default: return 0;
    endcase
  endfunction

  // Row width as the block sees it: zero counts as one, and it is capped.
  function automatic int eff_row_pixels();
    if (regs.width == 13'd0) return 1;
    if (int'(regs.width) > MAX_ROW_PIXELS) return MAX_ROW_PIXELS;
    return int'(regs.width);
  endfunction

  // Bytes that take a row up to the next 4-byte boundary.
  function automatic int row_pad_bytes(input int w, input int bpp);
    int nbytes;
    nbytes = (w * bpp + 7) / 8;
    return (4 - nbytes % 4) % 4;
  endfunction

  // Works out the pixels that one accepted beat gives and queues them.
  task automatic expand_beat(input item_t b);
    int     bpp, per_byte, w, h, c, idx;
    logic   row_last, img_last;
    pixel_t px;
    if (b.kind == KIND_PAL_WRITE) begin
      pal_mem[b.pal_index] = b.pal_color;
      return;
    end
    bpp = int'(regs.bpp);
    per_byte = pixels_per_byte(regs.bpp);
    if (per_byte == 0 || img_done) return;
    // Row padding bytes are swallowed.
    if (pad_left != 2'd0) begin
      pad_left = pad_left - 2'd1;
      return;
    end
    w = eff_row_pixels();
    h = (regs.height == 13'd0) ? 1 : int'(regs.height);
    row_last = 1'b0;
    for (c = per_byte - 1; c >= 0 && !row_last; c--) begin
      idx = (int'(b.data_byte) >> (c * bpp)) & ((1 << bpp) - 1);
      px.color = pal_mem[idx];
      if (regs.three_byte) px.color[31:24] = 8'h00;
      row_last = (int'(col_pos) + 1) >= w;
      img_last = row_last && ((int'(row_pos) + 1) >= h);
      if (!row_last) begin
        col_pos = col_pos + 13'd1;
      end else begin
        col_pos = '0;
        if (img_last) begin
          img_done = 1'b1;
          pad_left = '0;
        end else begin
          row_pos = row_pos + 13'd1;
          pad_left = 2'(row_pad_bytes(w, bpp));
        end
      end
      px.flags.last_of_byte = (c == 0) || row_last;
      px.flags.row_end = row_last;
      px.flags.image_end = img_last;
      pixels_due.push_back(px);
    end
  endtask

  task automatic report_mismatch(input string what);
    $display("ERROR at %0t: %s", $realtime, what);
    mismatches++;
  endtask

  // Driver: presents queued beats, holding each until it is taken.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) expand_beat(cur_beat);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (beats_to_send.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
          cur_beat = beats_to_send.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {cur_beat.data_byte, cur_beat.pal_color, cur_beat.pal_index};
          s_axis_tuser  <= (cur_beat.kind == KIND_PIXEL_BYTE) ? CMD_PIXEL_BYTE : CMD_PAL_WRITE;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks every output beat against the oldest expected pixel.
  always @(posedge clk_i) begin
    pixel_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (pixels_due.size() == 0) begin
          report_mismatch($sformatf("pixel %0d arrived with none expected", pixel_count));
        end else begin
          want = pixels_due.pop_front();
          if (m_axis_tdata !== want.color)
            report_mismatch($sformatf("pixel %0d colour %h, expected %h",
                                      pixel_count, m_axis_tdata, want.color));
          if (m_axis_tuser[0] !== want.flags.last_of_byte)
            report_mismatch($sformatf("pixel %0d last_of_byte %b, expected %b",
                                      pixel_count, m_axis_tuser[0], want.flags.last_of_byte));
          if (m_axis_tlast !== want.flags.row_end)
            report_mismatch($sformatf("pixel %0d row_end %b, expected %b",
                                      pixel_count, m_axis_tlast, want.flags.row_end));
          if (m_axis_tuser[1] !== want.flags.image_end)
            report_mismatch($sformatf("pixel %0d image_end %b, expected %b",
                                      pixel_count, m_axis_tuser[1], want.flags.image_end));
        end
        pixel_count++;
      end
      m_axis_tready <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Long receiver hold-off so that the block fills up and stalls its input.
  initial begin
    wait (hold_go);
    @(posedge clk_i);
    rx_hold <= 1'b1;
    repeat (150) @(posedge clk_i);
    rx_hold <= 1'b0;
  end

  initial begin
    #(12 * 400000);
    $display("FAILURE");
    $finish;
  end

  task automatic push_pal(input logic [7:0] idx, input logic [31:0] colour);
    item_t it;
    it.kind = KIND_PAL_WRITE;
    it.pal_index = idx;
    it.pal_color = colour;
    it.data_byte = 8'($urandom);
    beats_to_send.push_back(it);
    n_random++;
  endtask

  task automatic push_byte(input logic [7:0] value);
    item_t it;
    it.kind = KIND_PIXEL_BYTE;
    it.pal_index = 8'($urandom);
    it.pal_color = $urandom;
    it.data_byte = value;
    beats_to_send.push_back(it);
    if (pixels_per_byte(regs.bpp) != 0) n_random++;
  endtask

  // Waits until every beat is taken and every pixel seen, then lets the block settle.
  task automatic drain();
    @(posedge clk_i);
    while (beats_to_send.size() != 0 || s_axis_tvalid || pixels_due.size() != 0)
      @(posedge clk_i);
    repeat (24) @(posedge clk_i);
  endtask

  // Register write; only called while the block is idle.
  task automatic write_reg(input logic [1:0] addr, input logic [12:0] value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= addr;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (addr)
      REG_BPP:    regs.bpp = value[3:0];
      REG_WIDTH:  regs.width = value;
      REG_HEIGHT: regs.height = value;
      default:    regs.three_byte = value[0];
    endcase
  endtask

  // Rows of well-formed length with random content, some a byte short or long.
  task automatic send_rows(input int nrows);
    int r, k, bpp, need, nsend, pad;
    bpp = int'(regs.bpp);
    for (r = 0; r < nrows; r++) begin
      if (pixels_per_byte(regs.bpp) == 0) need = 3;
      else need = (eff_row_pixels() * bpp + 7) / 8;
      // Wide rows are cut short; a later width change ends them.
      nsend = (need > 16) ? 16 : need;
      pad = (need > 16 || pixels_per_byte(regs.bpp) == 0) ? 0 :
            row_pad_bytes(eff_row_pixels(), bpp);
      case ($urandom_range(9))
        0:       nsend++;
        1:       if (nsend > 1) nsend--;
        default: ;
      endcase
      for (k = 0; k < nsend + pad; k++) begin
        if ($urandom_range(99) < 12) push_pal(8'($urandom), $urandom);
        push_byte(8'($urandom));
      end
    end
  endtask

  // Stimulus sequence.
  initial begin
    logic [3:0]  pick_bpp;
    logic [12:0] pick_width;
    bit          first_phase;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Three pixels per row with one pad byte; the first byte reads an unwritten entry.
    write_reg(REG_HEIGHT, 13'd4096);
    write_reg(REG_WIDTH, 13'd3);
    push_byte(8'h00);
    push_pal(8'd0, 32'hFFFF_FFFF);
    push_pal(8'd255, 32'h8000_0001);
    push_pal(8'd1, 32'hA5C3_0F96);
    push_byte(8'hFF);
    push_byte(8'h01);
    push_byte(8'hAA);
    drain();

    // One bit per pixel, width above the cap, three-byte entries.
    write_reg(REG_BPP, 4'd1);
    write_reg(REG_WIDTH, 13'd8191);
    write_reg(REG_THREE_BYTE, 13'd1);
    push_byte(8'h5A);
    push_byte(8'hFF);
    push_byte(8'h00);
    drain();

    // Width lowered below the column reached: the next pixel ends the row.
    write_reg(REG_WIDTH, 13'd20);
    push_byte(8'h80);
    push_byte(8'h3C);
    drain();

    // Two bits per pixel with two pad bytes.
    write_reg(REG_BPP, 4'd2);
    write_reg(REG_WIDTH, 13'd5);
    write_reg(REG_THREE_BYTE, 13'd0);
    push_pal(8'd2, $urandom);
    push_pal(8'd3, $urandom);
    push_byte(8'hE4);
    push_byte(8'h1B);
    push_byte(8'h11);
    push_byte(8'h22);
    drain();

    // Four bits per pixel; the row ends on the first index of a byte.
    write_reg(REG_BPP, 4'd4);
    write_reg(REG_WIDTH, 13'd3);
    push_byte(8'h12);
    push_byte(8'h34);
    push_byte(8'h56);
    push_byte(8'h78);
    drain();

    // Unsupported index widths: data bytes are ignored.
    write_reg(REG_BPP, 4'd0);
    push_byte(8'h33);
    drain();
    write_reg(REG_BPP, 4'd3);
    push_byte(8'hC3);
    drain();
    write_reg(REG_BPP, 4'd15);
    push_byte(8'h0F);
    drain();
    write_reg(REG_HEIGHT, 13'd8191);

    // Random phases, each with its own settings.
    n_random = 0;
    first_phase = 1'b1;
    while (n_random < RANDOM_BEATS) begin
      drain();
      if (n_random < RANDOM_BEATS / 3) begin
        tx_idle_pct = 23;
        rx_idle_pct = 78;
      end else if (n_random < 2 * RANDOM_BEATS / 3) begin
        tx_idle_pct = 78;
        rx_idle_pct = 23;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      if ($urandom_range(99) < 6) begin
        pick_bpp = 4'($urandom);
        while (pixels_per_byte(pick_bpp) != 0) pick_bpp = 4'($urandom);
      end else begin
        pick_bpp = 4'(1 << $urandom_range(3));
      end
      case ($urandom_range(19))
        0:       pick_width = 13'd1;
        1:       pick_width = 13'd4096;
        2:       pick_width = 13'd8191;
        3:       pick_width = 13'd0;
        default: pick_width = 13'($urandom_range(2, 24));
      endcase
      if (first_phase) begin
        pick_bpp = 4'd1;
        pick_width = 13'd24;
      end
      write_reg(REG_BPP, pick_bpp);
      write_reg(REG_WIDTH, pick_width);
      write_reg(REG_THREE_BYTE, 13'($urandom_range(1)));
      if (first_phase) begin
        hold_go = 1'b1;
        send_rows(6);
        first_phase = 1'b0;
      end else begin
        send_rows($urandom_range(1, 5));
      end
    end
    drain();

    // Height of zero ends the image at the next row end; later bytes are ignored.
    write_reg(REG_BPP, 4'd8);
    write_reg(REG_WIDTH, 13'd0);
    write_reg(REG_HEIGHT, 13'd0);
    push_pal(8'($urandom), $urandom);
    repeat (6) push_byte(8'($urandom));
    drain();
    write_reg(REG_BPP, 4'd1);
    repeat (3) push_byte(8'($urandom));
    drain();

    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

/* files.f */
hdl/bpu_pkg.sv
hdl/bpu_fifo.sv
hdl/bpu_front.sv
hdl/bpu_back.sv
hdl/bmp_palette_pixel_unpacker.sv
verif/bmp_palette_pixel_unpacker_tb.sv
